// File: rtl/csw_pkg.sv
// ----------------------------------------------------------------------------
// csw_pkg: shared types, constants and the CRC step for the receiver
// Holds the reply codes, the generator reset value and the one-bit CRC update.
// ----------------------------------------------------------------------------
`default_nettype none

package csw_pkg;

  localparam int unsigned CRC_W = 16;

  typedef logic [CRC_W-1:0] crc_t;
  typedef logic [1:0]       reply_code_t;

  // Reply codes
  localparam reply_code_t REPLY_ACK_NEXT0 = 2'd0;
  localparam reply_code_t REPLY_ACK_NEXT1 = 2'd1;
  localparam reply_code_t REPLY_CRC_ERROR = 2'd2;

  // CCITT generator, x^16 term implied
  localparam crc_t GEN_RESET = 16'h1021;

  // Item held in the input register
  typedef struct packed {
    logic valid;
    logic frame_bit;
    logic frame_end;
  } in_item_t;

  // Shift one bit into the remainder, reduce when the top bit falls out
  function automatic crc_t crc_shift(input crc_t rem, input logic din, input crc_t gen);
    crc_t shifted;
    shifted = {rem[CRC_W-2:0], din};
    crc_shift = rem[CRC_W-1] ? (shifted ^ gen) : shifted;
  endfunction

endpackage

`default_nettype wire

// File: rtl/csw_if.sv
// ----------------------------------------------------------------------------
// csw_if: handshake channels of the receiver
// Frame bit channel, reply channel and generator write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface csw_frame_if;
  logic valid;
  logic ready;
  logic frame_bit;
  logic frame_end;
  modport source (output valid, frame_bit, frame_end, input ready);
  modport sink   (input valid, frame_bit, frame_end, output ready);
endinterface

interface csw_reply_if;
  logic       valid;
  logic       ready;
  logic [1:0] reply_code;
  modport source (output valid, reply_code, input ready);
  modport sink   (input valid, reply_code, output ready);
endinterface

interface csw_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] generator_low;
  modport source (output valid, generator_low, input ready);
  modport sink   (input valid, generator_low, output ready);
endinterface

`default_nettype wire

// File: rtl/crc16_stop_and_wait_receiver.sv
// ----------------------------------------------------------------------------
// crc16_stop_and_wait_receiver: CRC-16 checking stop-and-wait frame receiver
// Checks serial frames bit by bit and issues ack or CRC-error replies.
// ----------------------------------------------------------------------------
// Usage:
//   frame : one received bit per item, frame_end set on the last bit. The
//           first bit of each frame is its sequence number.
//   reply : at most one item per frame: ack with the next expected sequence
//           (0 or 1) or CRC error. A good duplicate frame gets no reply.
//   cfg   : writes the low 16 bits of the generator (x^16 implied); always
//           ready, to be written only while the receiver is idle.
//   Throughput is one bit item per cycle while replies are taken. A bit enters
//   the input register, then the remainder update and reply decision run in
//   one pass on the held bit and a reply is loaded into the reply register.
//   The limit is the single remainder register update. When the reply
//   register is full and not taken, a frame end waits in the input register
//   and the frame channel stalls; bits that cause no reply still flow. Reset
//   clears the remainder and expected sequence, arms for a new frame and
//   loads the generator with 0x1021.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_stop_and_wait_receiver
  import csw_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  csw_frame_if.sink   frame,
  csw_reply_if.source reply,
  csw_cfg_if.sink     cfg
);

  in_item_t    item;
  logic        advance;
  crc_t        generator;
  reply_code_t out_code;

  // Generator register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      generator <= GEN_RESET;
    end else if (cfg.valid) begin
      generator <= cfg.generator_low;
    end
  end

  csw_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (frame.valid),
    .in_ready (frame.ready),
    .in_bit   (frame.frame_bit),
    .in_end   (frame.frame_end),
    .advance  (advance),
    .item     (item)
  );

  csw_core u_core (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .advance   (advance),
    .generator (generator),
    .out_valid (reply.valid),
    .out_ready (reply.ready),
    .out_code  (out_code)
  );

  assign reply.reply_code = out_code;

  // Checks
  a_code_legal: assert property (@(posedge clk) disable iff (rst)
    reply.valid |-> (reply.reply_code != 2'd3))
    else $error("reply code out of range");

  a_ready_when_out_free: assert property (@(posedge clk) disable iff (rst)
    !reply.valid |-> frame.ready)
    else $error("frame channel stalled with empty reply register");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !reply.valid)
    else $error("reply valid right after reset");

  a_no_reply_without_item: assert property (@(posedge clk) disable iff (rst)
    (!reply.valid && !item.valid) |=> !reply.valid)
    else $error("reply raised without a held item");

endmodule

`default_nettype wire

// File: rtl/csw_in_stage.sv
// ----------------------------------------------------------------------------
// csw_in_stage: input register
// Captures one frame bit item; refills in the same cycle it is consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module csw_in_stage
  import csw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     in_bit,
  input  wire logic     in_end,
  input  wire logic     advance,
  output in_item_t      item
);

  in_item_t item_r;

  // Free when empty or when the held item moves on this cycle
  assign in_ready = !item_r.valid || advance;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_r.valid <= 1'b0;
    end else if (in_ready) begin
      item_r.valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item_r.frame_bit <= in_bit;
      item_r.frame_end <= in_end;
    end
  end

endmodule

`default_nettype wire

// File: rtl/csw_core.sv
// ----------------------------------------------------------------------------
// csw_core: CRC remainder, sequence tracking and reply register
// Processes one held item per cycle unless stalled; loads the reply register on frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module csw_core
  import csw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire in_item_t    item,
  output logic             advance,
  input  wire crc_t        generator,
  output logic             out_valid,
  input  wire logic        out_ready,
  output reply_code_t      out_code
);

  crc_t        remainder, remainder_next;
  logic        expected_seq;
  logic        frame_seq;
  logic        at_frame_start;
  logic        seq_now;
  logic        crc_bad;
  logic        seq_match;
  logic        produce;
  reply_code_t code_next;

  // Decision for the held item
  always_comb begin
    seq_now        = at_frame_start ? item.frame_bit : frame_seq;
    remainder_next = crc_shift(remainder, item.frame_bit, generator);
    crc_bad        = (remainder_next != '0);
    seq_match      = (seq_now == expected_seq);
    produce        = item.frame_end && (crc_bad || seq_match);
    code_next      = crc_bad ? REPLY_CRC_ERROR
                             : (expected_seq ? REPLY_ACK_NEXT0 : REPLY_ACK_NEXT1);
  end

  // Move on unless a reply is due and the reply register is still full
  assign advance = item.valid && (!produce || !out_valid || out_ready);

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      remainder      <= '0;
      expected_seq   <= 1'b0;
      frame_seq      <= 1'b0;
      at_frame_start <= 1'b1;
    end else if (advance) begin
      frame_seq <= seq_now;
      if (item.frame_end) begin
        remainder      <= '0;
        at_frame_start <= 1'b1;
        if (!crc_bad && seq_match) begin
          expected_seq <= !expected_seq;
        end
      end else begin
        remainder      <= remainder_next;
        at_frame_start <= 1'b0;
      end
    end
  end

  // Reply register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && produce) begin
      out_code <= code_next;
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the CRC-16 stop-and-wait receiver
// Feeds serial frames (good, corrupted, duplicate, short and noise) under
// several generator settings, predicts every reply and checks each one.
// ----------------------------------------------------------------------------
module tb_top;
  import csw_pkg::*;

  typedef struct packed {
    logic frame_bit;
    logic frame_end;
  } bit_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  csw_frame_if frame_ch ();
  csw_reply_if reply_ch ();
  csw_cfg_if   cfg_ch ();

  crc16_stop_and_wait_receiver dut (
    .clk   (clk),
    .rst   (rst),
    .frame (frame_ch),
    .reply (reply_ch),
    .cfg   (cfg_ch)
  );

  always #4 clk = ~clk;

  // Pending bits, expected replies, bookkeeping
  bit_item_t   pending_bits[$];
  reply_code_t expected_replies[$];
  int          mismatch_cnt = 0;
  int          replies_seen = 0;
  int          bits_queued  = 0;
  int          send_gap     = 0;
  int          recv_stall   = 0;
  bit          no_gaps      = 1'b0;
  bit          long_hold_done = 1'b0;

  // Receiver state as the bench sees it
  crc_t gen_reg       = GEN_RESET;
  crc_t rx_rem        = '0;
  logic rx_expect_seq = 1'b0;
  logic rx_frame_seq  = 1'b0;
  logic rx_at_start   = 1'b1;
  logic build_expect  = 1'b0;  // rough guess used only to bias frame building

  // One CRC step: shift the bit in, reduce when bit 15 falls out
  function automatic crc_t crc_next(input crc_t rem, input logic b, input crc_t gen);
    logic [16:0] wide;
    wide = {rem, b};
    if (wide[16]) wide = wide ^ {1'b1, gen};
    return wide[15:0];
  endfunction

  // Update receiver state for one accepted bit, queue the reply if any
  function automatic void rx_accept_bit(input logic b, input logic last);
    if (rx_at_start) begin
      rx_frame_seq = b;
      rx_at_start  = 1'b0;
    end
    rx_rem = crc_next(rx_rem, b, gen_reg);
    if (last) begin
      if (rx_rem != '0) begin
        expected_replies.push_back(REPLY_CRC_ERROR);
      end else if (rx_frame_seq == rx_expect_seq) begin
        rx_expect_seq = ~rx_expect_seq;
        expected_replies.push_back(rx_expect_seq ? REPLY_ACK_NEXT1 : REPLY_ACK_NEXT0);
      end
      rx_rem      = '0;
      rx_at_start = 1'b1;
    end
  endfunction

  // Idle length: mostly none or short, sometimes long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Queue n bits, bit n-1 goes first, end flag on the last
  task automatic queue_raw(input logic [79:0] v, input int n);
    bit_item_t it;
    for (int i = n - 1; i >= 0; i--) begin
      it.frame_bit = v[i];
      it.frame_end = (i == 0);
      pending_bits.push_back(it);
    end
    bits_queued += n;
  endtask

  // Sequence bit, data, then 16 check bits so the whole frame divides evenly
  task automatic queue_frame(input logic seq, input int dlen, input bit corrupt);
    logic [79:0] v;
    crc_t        r;
    logic        b;
    int          n;
    v = 80'(seq);
    r = crc_next('0, seq, gen_reg);
    for (int i = 0; i < dlen; i++) begin
      b = 1'($urandom_range(0, 1));
      v = {v[78:0], b};
      r = crc_next(r, b, gen_reg);
    end
    for (int i = 0; i < 16; i++) r = crc_next(r, 1'b0, gen_reg);
    v = {v[63:0], r};
    n = dlen + 17;
    if (corrupt) v[$urandom_range(0, n - 1)] ^= 1'b1;
    else if (seq == build_expect) build_expect = ~build_expect;
    queue_raw(v, n);
  endtask

  task automatic write_generator(input crc_t value);
    @(posedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.generator_low <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    gen_reg = value;
  endtask

  // Wait until every bit went in and every reply came out, then let the pipe settle
  task automatic wait_drained();
    while (pending_bits.size() != 0 || frame_ch.valid || expected_replies.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Random frames: mostly well formed, some short, some pure noise
  task automatic queue_random(input int target);
    logic [79:0] v;
    int          r;
    int          n;
    logic        seq;
    int          stop_at;
    stop_at = bits_queued + target;
    while (bits_queued < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        seq = ($urandom_range(0, 3) != 0) ? build_expect : ~build_expect;
        n   = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 16) : $urandom_range(17, 48);
        queue_frame(seq, n, $urandom_range(0, 4) == 0);
      end else if (r < 85) begin
        // short frame, all zero (good, never reduced) or with a stray one
        n = $urandom_range(1, 15);
        v = '0;
        if ($urandom_range(0, 2) == 0) v[$urandom_range(0, n - 1)] = 1'b1;
        queue_raw(v, n);
      end else begin
        n = $urandom_range(1, 40);
        v = '0;
        for (int i = 0; i < n; i++) v[i] = 1'($urandom_range(0, 1));
        queue_raw(v, n);
      end
    end
  endtask

  // Frame driver
  always @(posedge clk) begin
    bit_item_t it;
    if (rst) begin
      frame_ch.valid     <= 1'b0;
      frame_ch.frame_bit <= 1'b0;
      frame_ch.frame_end <= 1'b0;
      send_gap = 0;
    end else begin
      if (frame_ch.valid && frame_ch.ready)
        rx_accept_bit(frame_ch.frame_bit, frame_ch.frame_end);
      if (!frame_ch.valid || frame_ch.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          frame_ch.valid <= 1'b0;
        end else if (pending_bits.size() != 0) begin
          it = pending_bits.pop_front();
          frame_ch.valid     <= 1'b1;
          frame_ch.frame_bit <= it.frame_bit;
          frame_ch.frame_end <= it.frame_end;
          send_gap = pick_gap();
        end else begin
          frame_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor and receiver back-pressure
  always @(posedge clk) begin
    reply_code_t want;
    if (rst) begin
      reply_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (reply_ch.valid && reply_ch.ready) begin
        replies_seen++;
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected reply item, actual reply_code %0d", $time,
                   reply_ch.reply_code);
          mismatch_cnt++;
        end else begin
          want = expected_replies.pop_front();
          if (reply_ch.reply_code !== want) begin
            $display("%0t: reply_code mismatch, expected %0d, actual %0d", $time, want,
                     reply_ch.reply_code);
            mismatch_cnt++;
          end
        end
      end
      // one long hold so the reply register fills and the frame input stalls
      if (!long_hold_done && replies_seen >= 15) begin
        long_hold_done = 1'b1;
        recv_stall = 400;
      end
      if (recv_stall != 0) begin
        recv_stall--;
        reply_ch.ready <= 1'b0;
      end else begin
        reply_ch.ready <= 1'b1;
        recv_stall = pick_gap();
      end
    end
  end

  // Stimulus and end of run
  initial begin
    crc_t gens[5];
    frame_ch.valid       = 1'b0;
    frame_ch.frame_bit   = 1'b0;
    frame_ch.frame_end   = 1'b0;
    reply_ch.ready       = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.generator_low = '0;
    gens[0] = 16'hFFFF;
    gens[1] = 16'h0000;
    gens[2] = 16'h8005;
    gens[3] = crc_t'($urandom_range(0, 65535));
    gens[4] = GEN_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: one-bit frames, duplicates, short frames, a full good frame
    queue_raw(80'b0, 1);       // good, seq matches: ack next 1
    queue_raw(80'b1, 1);       // seq matches but remainder nonzero: crc error
    queue_raw(80'b0, 1);       // good duplicate: no reply
    queue_raw(80'b000, 3);     // short all-zero duplicate
    queue_raw(80'b1000, 4);    // short frame with a one: crc error
    build_expect = 1'b1;
    queue_frame(1'b1, 0, 1'b0); // full codeword, seq 1: ack next 0
    wait_drained();

    // Random phases under different generators
    for (int p = 0; p < 5; p++) begin
      write_generator(gens[p]);
      no_gaps = (p == 2);
      queue_random(300);
      wait_drained();
    end

    if (mismatch_cnt == 0 && expected_replies.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
